/* rtl/ist_pkg.sv */
// Package for the IMU sample scale and tilt unit: item types, pipeline layout
// constants, register indexes and the CORDIC arctangent table. Depends on nothing.
package ist_pkg;

    localparam int RAW_W   = 16;
    localparam int SCALE_W = 20;
    localparam int OUT_W   = 28;
    localparam int ANGLE_W = 16;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 23;

    // Stage layout: squares, sum, square-root digits, rounding, CORDIC, output.
    localparam int SQRT_FIRST   = 2;
    localparam int ROUND_STAGE  = SQRT_FIRST + SQRT_STEPS;
    localparam int CORDIC_FIRST = ROUND_STAGE + 1;
    localparam int LAST_STAGE   = CORDIC_FIRST + CORDIC_STEPS;
    localparam int NUM_STAGES   = LAST_STAGE + 1;

    localparam int CX_W = 52;
    localparam int CZ_W = 26;

    localparam logic signed [ANGLE_W-1:0] DEG90_Q88 = 16'sd23040;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 2'd1;

    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 20'd2048;
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 20'd256140;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x_raw;
        logic signed [RAW_W-1:0] accel_y_raw;
        logic signed [RAW_W-1:0] accel_z_raw;
        logic signed [RAW_W-1:0] gyro_x_raw;
        logic signed [RAW_W-1:0] gyro_y_raw;
        logic signed [RAW_W-1:0] gyro_z_raw;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]   accel_x_g;
        logic signed [OUT_W-1:0]   accel_y_g;
        logic signed [OUT_W-1:0]   accel_z_g;
        logic signed [OUT_W-1:0]   rate_x_dps;
        logic signed [OUT_W-1:0]   rate_y_dps;
        logic signed [OUT_W-1:0]   rate_z_dps;
        logic signed [ANGLE_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] roll_deg;
    } result_t;

    typedef struct packed {
        logic             neg;
        logic             mag_zero;
        logic             s_zero;
        logic [RAW_W-1:0] mag;
    } tilt_flags_t;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic signed [CZ_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [CZ_W-1:0] v;
        begin
            case (i)
                5'd0:    v = 26'sd2949120;
                5'd1:    v = 26'sd1740967;
                5'd2:    v = 26'sd919879;
                5'd3:    v = 26'sd466945;
                5'd4:    v = 26'sd234379;
                5'd5:    v = 26'sd117304;
                5'd6:    v = 26'sd58666;
                5'd7:    v = 26'sd29335;
                5'd8:    v = 26'sd14668;
                5'd9:    v = 26'sd7334;
                5'd10:   v = 26'sd3667;
                5'd11:   v = 26'sd1833;
                5'd12:   v = 26'sd917;
                5'd13:   v = 26'sd458;
                5'd14:   v = 26'sd229;
                5'd15:   v = 26'sd115;
                5'd16:   v = 26'sd57;
                5'd17:   v = 26'sd29;
                5'd18:   v = 26'sd14;
                5'd19:   v = 26'sd7;
                5'd20:   v = 26'sd4;
                5'd21:   v = 26'sd2;
                5'd22:   v = 26'sd1;
                default: v = 26'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/ist_stream_if.sv */
// Valid/ready stream interface carrying one item of payload type T.
// Depends on nothing; the payload types come from ist_pkg at the point of use.
interface ist_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ist_tilt_lane.sv */
// One tilt-angle lane: squares, digit-by-digit square root, vectoring CORDIC, rounding.
// Depends on ist_pkg; stage enables come from the valid chain in the top level.
module ist_tilt_lane (
    input  logic                                clk,
    input  logic [ist_pkg::NUM_STAGES-1:0]      en,
    input  logic signed [ist_pkg::RAW_W-1:0]    num,
    input  logic signed [ist_pkg::RAW_W-1:0]    a,
    input  logic signed [ist_pkg::RAW_W-1:0]    b,
    output logic signed [ist_pkg::ANGLE_W-1:0]  angle
);
    import ist_pkg::*;

    tilt_flags_t flags_reg [NUM_STAGES-1];
    logic [31:0] sqa_reg, sqb_reg, sum_reg;
    logic [63:0] rem_reg [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS];
    logic signed [CX_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [CZ_W-1:0] cz_reg [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] angle_reg;

    logic [RAW_W:0]  mag_wide;
    logic [31:0]     sum_next;
    logic [32:0]     root;
    tilt_flags_t     flags_in;
    tilt_flags_t     flags_sum;
    logic signed [31:0] sqa_full, sqb_full;

    assign mag_wide = num[RAW_W-1] ? -{num[RAW_W-1], num} : {num[RAW_W-1], num};
    assign sqa_full = a * a;
    assign sqb_full = b * b;
    assign sum_next = sqa_reg + sqb_reg;

    always_comb
    begin
        flags_in.neg      = num[RAW_W-1];
        flags_in.mag_zero = (num == '0);
        flags_in.s_zero   = 1'b0;
        flags_in.mag      = mag_wide[RAW_W-1:0];
    end

    always_comb
    begin
        flags_sum        = flags_reg[0];
        flags_sum.s_zero = (sum_next == '0);
    end

    // Squares, then their sum; the zero-denominator flag is settled at the sum.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqa_reg      <= 32'(sqa_full);
            sqb_reg      <= 32'(sqb_full);
            flags_reg[0] <= flags_in;
        end
        if (en[1])
        begin
            sum_reg      <= sum_next;
            flags_reg[1] <= flags_sum;
        end
        for (int s = 2; s < NUM_STAGES - 1; s++)
        begin
            if (en[s])
            begin
                flags_reg[s] <= flags_reg[s-1];
            end
        end
    end

    // One result bit of the square root per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] rem_in, res_in;
        logic [64:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in = {sum_reg, 32'd0};
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        assign trial = {1'b0, res_in} + {1'b0, BIT};

        always_ff @(posedge clk)
        begin
            if (en[SQRT_FIRST + j])
            begin
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[j] <= rem_in - trial[63:0];
                    res_reg[j] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    res_reg[j] <= res_in >> 1;
                end
            end
        end
    end

    // Round the root to nearest and load the CORDIC start vector.
    assign root = res_reg[SQRT_STEPS-1][32:0]
                + 33'(rem_reg[SQRT_STEPS-1] > res_reg[SQRT_STEPS-1]);

    always_ff @(posedge clk)
    begin
        if (en[ROUND_STAGE])
        begin
            cx_reg[0] <= CX_W'(root) <<< 14;
            cy_reg[0] <= CX_W'(flags_reg[ROUND_STAGE-1].mag) <<< 30;
            cz_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        logic signed [CX_W-1:0] xs, ys;
        logic signed [CZ_W-1:0] at;

        assign xs = cx_reg[k] >>> k;
        assign ys = cy_reg[k] >>> k;
        assign at = atan_entry(5'(k));

        always_ff @(posedge clk)
        begin
            if (en[CORDIC_FIRST + k])
            begin
                if (cy_reg[k] > 0)
                begin
                    cx_reg[k+1] <= cx_reg[k] + ys;
                    cy_reg[k+1] <= cy_reg[k] - xs;
                    cz_reg[k+1] <= cz_reg[k] + at;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] - ys;
                    cy_reg[k+1] <= cy_reg[k] + xs;
                    cz_reg[k+1] <= cz_reg[k] - at;
                end
            end
        end
    end

    // Round to Q8.8, clamp to 90 degrees and apply the special cases.
    logic [CZ_W-1:0]   z_pos;
    logic [CZ_W-1:0]   z_rnd;
    logic [ANGLE_W-1:0] mag_q88;
    logic signed [ANGLE_W-1:0] angle_next;
    tilt_flags_t       ff;

    assign ff    = flags_reg[LAST_STAGE-1];
    assign z_pos = cz_reg[CORDIC_STEPS][CZ_W-1] ? '0 : cz_reg[CORDIC_STEPS];
    assign z_rnd = (z_pos + CZ_W'(128)) >> 8;
    assign mag_q88 = (z_rnd > CZ_W'(DEG90_Q88)) ? DEG90_Q88 : z_rnd[ANGLE_W-1:0];

    always_comb
    begin
        if (ff.mag_zero)
            angle_next = '0;
        else if (ff.s_zero)
            angle_next = ff.neg ? -DEG90_Q88 : DEG90_Q88;
        else
            angle_next = ff.neg ? -$signed(mag_q88) : $signed(mag_q88);
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST_STAGE])
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

/* rtl/imu_sample_scale_and_tilt_unit.sv */
// Top level of the IMU sample scale and tilt unit: scale registers, valid chain,
// raw-sample delay line, output scaling. Depends on ist_pkg, ist_stream_if, ist_tilt_lane.
//
// Each item is one six-axis sample. The unit returns one result item per sample:
// the three accelerometer axes times accel_scale and the three gyro axes times
// gyro_scale, each shifted right by 8 into signed Q.16, plus pitch and roll in
// signed Q8.8 degrees. The pipeline has 59 register stages, counting the one that
// takes the sample in, and a new sample is taken in every cycle unless a stalled
// output has filled the whole pipeline.
// Most of its length is the 32 stages of the square-root unit (one result bit
// per stage) followed by 23 stages of the vectoring CORDIC (one rotation per
// stage). Each stage holds its item until the next stage is free, so bubbles
// close up and a stalled output register does not stop intake until the whole
// pipeline is full. The scale registers are written through cfg_we, cfg_index
// and cfg_data and must only change while the unit holds no item.
module imu_sample_scale_and_tilt_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ist_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ist_pkg::SCALE_W-1:0]       cfg_data,
    ist_stream_if.sink                        sample,
    ist_stream_if.source                      result
);
    import ist_pkg::*;

    logic [SCALE_W-1:0]    accel_scale_reg, gyro_scale_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;
    sample_t               raw_reg [NUM_STAGES-1];
    result_t               out_reg;
    result_t               out_next;
    logic signed [ANGLE_W-1:0] pitch, roll;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= ACCEL_SCALE_RST;
            gyro_scale_reg  <= GYRO_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            en[s] = !valid_reg[s] || en[s+1];
    end

    assign sample.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (en[0])
                valid_reg[0] <= sample.valid;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (en[s])
                    valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // The raw sample travels alongside the angle lanes and is scaled at the end.
    always_ff @(posedge clk)
    begin
        if (en[0])
            raw_reg[0] <= sample.data;
        for (int s = 1; s < NUM_STAGES - 1; s++)
        begin
            if (en[s])
                raw_reg[s] <= raw_reg[s-1];
        end
    end

    ist_tilt_lane u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (sample.data.accel_x_raw),
        .a     (sample.data.accel_y_raw),
        .b     (sample.data.accel_z_raw),
        .angle (pitch)
    );

    ist_tilt_lane u_roll (
        .clk   (clk),
        .en    (en),
        .num   (sample.data.accel_y_raw),
        .a     (sample.data.accel_x_raw),
        .b     (sample.data.accel_z_raw),
        .angle (roll)
    );

    // Signed raw times unsigned scale; bits 35..8 are the shifted Q.16 value.
    function automatic logic signed [OUT_W-1:0] scale_axis(
        input logic signed [RAW_W-1:0] raw,
        input logic [SCALE_W-1:0]      scale
    );
        logic signed [RAW_W+SCALE_W:0] p;
        begin
            p = raw * $signed({1'b0, scale});
            return p[OUT_W+7:8];
        end
    endfunction

    sample_t last_raw;
    assign last_raw = raw_reg[NUM_STAGES-2];

    always_comb
    begin
        out_next.accel_x_g  = scale_axis(last_raw.accel_x_raw, accel_scale_reg);
        out_next.accel_y_g  = scale_axis(last_raw.accel_y_raw, accel_scale_reg);
        out_next.accel_z_g  = scale_axis(last_raw.accel_z_raw, accel_scale_reg);
        out_next.rate_x_dps = scale_axis(last_raw.gyro_x_raw, gyro_scale_reg);
        out_next.rate_y_dps = scale_axis(last_raw.gyro_y_raw, gyro_scale_reg);
        out_next.rate_z_dps = scale_axis(last_raw.gyro_z_raw, gyro_scale_reg);
        out_next.pitch_deg  = '0;
        out_next.roll_deg   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
            out_reg <= out_next;
    end

    always_comb
    begin
        result.data           = out_reg;
        result.data.pitch_deg = pitch;
        result.data.roll_deg  = roll;
    end

    assign result.valid = valid_reg[NUM_STAGES-1];

endmodule
